### hw/rtl/bez_sub_pkg.sv
// shared types, widths and interpolation helpers for the bezier subdivide unit
`default_nettype none

package bez_sub_pkg;

  localparam int COORD_W  = 32;                       // signed q16.16 coordinate
  localparam int T_FRAC   = 16;                       // fraction bits of t
  localparam int T_W      = T_FRAC + 1;               // t field, one included
  localparam int PROD_W   = COORD_W + T_FRAC + 3;     // (b - a) * t, signed
  localparam int N_PTS    = 7;                        // points of a cubic split
  localparam int IDX_W    = 3;
  localparam int N_STAGES = 7;
  localparam int N_CTRL   = 4;

  localparam int IN_DATA_W  = ((2 * N_CTRL * COORD_W + T_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_W + IDX_W + 7) / 8) * 8;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  localparam logic FUNC_QUAD  = 1'b0;
  localparam logic FUNC_CUBIC = 1'b1;

  localparam logic [IDX_W-1:0] IDX_QUAD_LAST  = 3'd4;
  localparam logic [IDX_W-1:0] IDX_CUBIC_LAST = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [T_W-1:0]            tpar_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } xy_t;

  typedef struct packed {
    prod_t y;
    prod_t x;
  } prod_xy_t;

  // (b - a) * t, full precision
  function automatic prod_t lerp_mul(coord_t a, coord_t b, tpar_t t);
    logic signed [COORD_W:0] d;
    logic signed [T_W:0]     ts;
    prod_t                   p;
    d  = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    ts = {1'b0, t};
    p  = d * ts;
    return p;
  endfunction

  // a + floor(prod / 2^T_FRAC); the result lies between the endpoints
  function automatic coord_t lerp_add(coord_t a, prod_t p);
    coord_t r;
    r = a + coord_t'(p[COORD_W+T_FRAC-1:T_FRAC]);
    return r;
  endfunction

  function automatic prod_xy_t lerp_mul_xy(xy_t a, xy_t b, tpar_t t);
    prod_xy_t r;
    r.x = lerp_mul(a.x, b.x, t);
    r.y = lerp_mul(a.y, b.y, t);
    return r;
  endfunction

  function automatic xy_t lerp_add_xy(xy_t a, prod_xy_t p);
    xy_t r;
    r.x = lerp_add(a.x, p.x);
    r.y = lerp_add(a.y, p.y);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bezier_curve_subdivide_unit.sv
// bezier curve split at t by de casteljau interpolation, streamed point by point
//
//  channel | dir | tdata                                   | tuser / tlast
//  --------+-----+-----------------------------------------+--------------------
//  in_     | in  | p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y t | tuser: func
//  out_    | out | out_x out_y point_index                 | tlast: last
//
// a curve spends seven register stages in the interpolation pipeline (three
// multiply stages and three add stages after the input register), then its
// points leave one per cycle, while out_tready holds, through the output shift
// register: 7 for a cubic, 5 for a quadratic. the single output port sets the
// sustained rate: a curve loads as the last point of the one before leaves, and
// the pipeline keeps taking curves while points drain. reset clears the stage
// valid bits, busy flag and point counter only. a stall on out_tready freezes
// each full stage with only full stages after it; nothing drops or repeats.
`default_nettype none

module bezier_curve_subdivide_unit
  import bez_sub_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    in_tvalid,
  output logic                   in_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t, zero padding
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  // func
  input  wire  [0:0]             in_tuser,

  output logic                   out_tvalid,
  input  wire                    out_tready,
  // out_x, out_y, point_index, zero padding
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tlast
);

  // everything a curve carries down the pipeline; later stages fill in more
  typedef struct packed {
    logic       func;
    tpar_t      t;
    xy_t [N_CTRL-1:0] p;
    xy_t        ab;
    xy_t        bc;
    xy_t        cd;
    xy_t        m1;
    xy_t        m2;
    xy_t        mm;
    prod_xy_t   pr_a;
    prod_xy_t   pr_b;
    prod_xy_t   pr_c;
  } pipe_t;

  pipe_t               pipe_r   [N_STAGES];
  pipe_t               pipe_nxt [N_STAGES];
  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES-1:0] en;

  // output side: shift register of the points still to send
  xy_t              pts_r [N_PTS];
  logic [IDX_W-1:0] cnt_r;
  logic             cubic_r;
  logic             busy_r;
  logic             last_now;
  logic             out_take;
  logic             load;

  tpar_t            t_raw;
  tpar_t            t_sat;

  assign last_now = cubic_r ? (cnt_r == IDX_CUBIC_LAST) : (cnt_r == IDX_QUAD_LAST);
  assign out_take = busy_r && out_tready;
  // the final stage hands over when the shift register is empty or emptying
  assign load     = v_r[N_STAGES-1] && (!busy_r || (out_take && last_now));

  // a stage moves on when it is empty or its successor moves on
  always_comb begin
    en[N_STAGES-1] = !v_r[N_STAGES-1] || load;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  // t above one saturates to one; with t at one the interpolation yields b
  assign t_raw = in_tdata[2*N_CTRL*COORD_W +: T_W];
  assign t_sat = t_raw[T_FRAC] ? T_ONE : t_raw;

  always_comb begin
    // stage 0: unpack the transaction
    pipe_nxt[0]      = '0;
    pipe_nxt[0].func = in_tuser[0];
    pipe_nxt[0].t    = t_sat;
    for (int i = 0; i < N_CTRL; i++) begin
      pipe_nxt[0].p[i].x = in_tdata[(2*i)*COORD_W +: COORD_W];
      pipe_nxt[0].p[i].y = in_tdata[(2*i+1)*COORD_W +: COORD_W];
    end

    // stage 1: first level products
    pipe_nxt[1]      = pipe_r[0];
    pipe_nxt[1].pr_a = lerp_mul_xy(pipe_r[0].p[0], pipe_r[0].p[1], pipe_r[0].t);
    pipe_nxt[1].pr_b = lerp_mul_xy(pipe_r[0].p[1], pipe_r[0].p[2], pipe_r[0].t);
    pipe_nxt[1].pr_c = lerp_mul_xy(pipe_r[0].p[2], pipe_r[0].p[3], pipe_r[0].t);

    // stage 2: ab, bc, cd
    pipe_nxt[2]    = pipe_r[1];
    pipe_nxt[2].ab = lerp_add_xy(pipe_r[1].p[0], pipe_r[1].pr_a);
    pipe_nxt[2].bc = lerp_add_xy(pipe_r[1].p[1], pipe_r[1].pr_b);
    pipe_nxt[2].cd = lerp_add_xy(pipe_r[1].p[2], pipe_r[1].pr_c);

    // stage 3: second level products
    pipe_nxt[3]      = pipe_r[2];
    pipe_nxt[3].pr_a = lerp_mul_xy(pipe_r[2].ab, pipe_r[2].bc, pipe_r[2].t);
    pipe_nxt[3].pr_b = lerp_mul_xy(pipe_r[2].bc, pipe_r[2].cd, pipe_r[2].t);

    // stage 4: abbc, bccd (abbc is the quadratic midpoint)
    pipe_nxt[4]    = pipe_r[3];
    pipe_nxt[4].m1 = lerp_add_xy(pipe_r[3].ab, pipe_r[3].pr_a);
    pipe_nxt[4].m2 = lerp_add_xy(pipe_r[3].bc, pipe_r[3].pr_b);

    // stage 5: third level product
    pipe_nxt[5]      = pipe_r[4];
    pipe_nxt[5].pr_a = lerp_mul_xy(pipe_r[4].m1, pipe_r[4].m2, pipe_r[4].t);

    // stage 6: cubic midpoint
    pipe_nxt[6]    = pipe_r[5];
    pipe_nxt[6].mm = lerp_add_xy(pipe_r[5].m1, pipe_r[5].pr_a);
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < N_STAGES; k++) begin
      if (en[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // output shift register, points in sending order
  always_ff @(posedge clk) begin
    if (load) begin
      pts_r[0] <= pipe_r[N_STAGES-1].p[0];
      pts_r[1] <= pipe_r[N_STAGES-1].ab;
      pts_r[2] <= pipe_r[N_STAGES-1].m1;
      if (pipe_r[N_STAGES-1].func == FUNC_CUBIC) begin
        pts_r[3] <= pipe_r[N_STAGES-1].mm;
        pts_r[4] <= pipe_r[N_STAGES-1].m2;
        pts_r[5] <= pipe_r[N_STAGES-1].cd;
        pts_r[6] <= pipe_r[N_STAGES-1].p[3];
      end else begin
        pts_r[3] <= pipe_r[N_STAGES-1].bc;
        pts_r[4] <= pipe_r[N_STAGES-1].p[2];
        pts_r[5] <= pipe_r[N_STAGES-1].p[2];
        pts_r[6] <= pipe_r[N_STAGES-1].p[2];
      end
      cubic_r <= pipe_r[N_STAGES-1].func;
    end else if (out_take) begin
      for (int i = 0; i < N_PTS - 1; i++) begin
        pts_r[i] <= pts_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (out_take) begin
        if (last_now) begin
          busy_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = last_now;
  assign out_tdata  = {{(OUT_DATA_W - 2*COORD_W - IDX_W){1'b0}}, cnt_r, pts_r[0].y, pts_r[0].x};

endmodule

`default_nettype wire

### hw/rtl/bez_sub_checker.sv
// port-level checks for the bezier subdivide unit, bound to the top level
`default_nettype none

module bez_sub_checker
  import bez_sub_pkg::*;
(
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_tvalid,
  input wire                   out_tready,
  input wire [OUT_DATA_W-1:0]  out_tdata,
  input wire                   out_tlast
);

  logic [IDX_W-1:0] idx;
  assign idx = out_tdata[2*COORD_W +: IDX_W];

  // a held point keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // the final point closes a sequence of five or seven
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (idx == IDX_QUAD_LAST) || (idx == IDX_CUBIC_LAST))
    else $error("tlast on a point that does not end a split");

  // inside a sequence the points follow one another without gaps
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast
      |=> out_tvalid && (idx == IDX_W'($past(idx) + 3'd1)))
    else $error("point index skipped or sequence broken");

  // a new sequence starts at the first point
  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || (idx == '0))
    else $error("new split does not start at index zero");

  // no index beyond a cubic split
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (idx > IDX_CUBIC_LAST) |-> 1'b0)
    else $error("point index out of range");

endmodule

bind bezier_curve_subdivide_unit bez_sub_checker u_bez_sub_checker (.*);

`default_nettype wire
